@@ sv/length_prefix_deframer_unit_macros.svh @@
// Assertion macros for the length-prefix deframer.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIX_DEFRAMER_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lpd_pkg.sv @@
package lpd_pkg;

  // Frame outcome codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_EOS        = 3'd1,
    ST_TRUNC_HDR  = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_TOO_LARGE  = 3'd4,
    ST_TRUNC_PAY  = 3'd5
  } lpd_status_e;

  localparam int unsigned LEN_W          = 32;
  localparam int unsigned CNT_W          = 3;
  localparam logic [LEN_W-1:0] MAX_RESET = 32'd1048576;
  localparam int unsigned QUEUE_DEPTH    = 2;

  // One result transaction as it travels from the front to the queue
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        last_byte;
    lpd_status_e status;
    logic        status_valid;
  } lpd_result_t;

endpackage

@@ sv/lpd_front.sv @@
module lpd_front #(
  parameter int unsigned PREFIX_BYTES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_byte_i,
  input  logic                stream_end_i,
  input  logic                cfg_we_i,
  input  logic [31:0]         cfg_wdata_i,
  output logic                push_o,
  output lpd_pkg::lpd_result_t result_o
);
  import lpd_pkg::*;

  localparam logic [CNT_W-1:0] HDR_CODE = CNT_W'(PREFIX_BYTES % (1 << CNT_W));

  logic              in_payload_q, in_payload_d;
  logic [CNT_W-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [LEN_W-1:0]  rem_q, rem_d;
  logic [LEN_W-1:0]  max_q;

  logic [LEN_W-1:0]  len_next;
  logic [CNT_W-1:0]  cnt_next;

  // Gather the next header byte, saturating on overflow of a long header
  assign len_next = (len_q[LEN_W-1:LEN_W-8] != 8'd0) ? '1 : {len_q[LEN_W-9:0], data_byte_i};
  assign cnt_next = hdr_cnt_q + CNT_W'(1);

  // Classify the accepted transaction and advance the frame state
  always_comb begin
    in_payload_d = in_payload_q;
    hdr_cnt_d    = hdr_cnt_q;
    len_d        = len_q;
    rem_d        = rem_q;
    push_o       = 1'b0;
    result_o     = '{payload_byte: 8'd0, byte_valid: 1'b0, last_byte: 1'b0,
                     status: ST_OK, status_valid: 1'b0};
    if (accept_i) begin
      if (stream_end_i) begin
        push_o                = 1'b1;
        result_o.status_valid = 1'b1;
        if (in_payload_q) begin
          result_o.status = ST_TRUNC_PAY;
        end else if (hdr_cnt_q == '0) begin
          result_o.status = ST_EOS;
        end else begin
          result_o.status = ST_TRUNC_HDR;
        end
        in_payload_d = 1'b0;
        hdr_cnt_d    = '0;
        len_d        = '0;
        rem_d        = '0;
      end else if (in_payload_q) begin
        push_o                = 1'b1;
        result_o.payload_byte = data_byte_i;
        result_o.byte_valid   = 1'b1;
        if (rem_q[LEN_W-1:1] == '0) begin
          // final byte: close the frame
          result_o.last_byte    = 1'b1;
          result_o.status_valid = 1'b1;
          in_payload_d = 1'b0;
          hdr_cnt_d    = '0;
          len_d        = '0;
          rem_d        = '0;
        end else begin
          rem_d = rem_q - LEN_W'(1);
        end
      end else if (cnt_next == HDR_CODE) begin
        hdr_cnt_d = '0;
        len_d     = '0;
        if (len_next == '0) begin
          push_o                = 1'b1;
          result_o.status       = ST_EMPTY;
          result_o.status_valid = 1'b1;
        end else if (len_next > max_q) begin
          push_o                = 1'b1;
          result_o.status       = ST_TOO_LARGE;
          result_o.status_valid = 1'b1;
        end else begin
          in_payload_d = 1'b1;
          rem_d        = len_next;
        end
      end else begin
        hdr_cnt_d = cnt_next;
        len_d     = len_next;
      end
    end
  end

  // Hold frame state and the length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      hdr_cnt_q    <= '0;
      len_q        <= '0;
      rem_q        <= '0;
      max_q        <= MAX_RESET;
    end else begin
      in_payload_q <= in_payload_d;
      hdr_cnt_q    <= hdr_cnt_d;
      len_q        <= len_d;
      rem_q        <= rem_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

endmodule

@@ sv/lpd_queue.sv @@
module lpd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lpd_pkg::lpd_result_t push_data_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output lpd_pkg::lpd_result_t head_o
);
  import lpd_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);

  lpd_result_t         entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CNT_QW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance the pointers, wrapping at the depth, and update the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_QW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/length_prefix_deframer_unit.sv @@
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o data_byte_i, stream_end_i
// out       output     out_valid_o/out_stall_i payload_byte_o, byte_valid_o, last_byte_o,
//                                              status_o, status_valid_o
// cfg       input      cfg_we_i                cfg_wdata_i (max_payload_bytes)
//
// One transaction is taken per cycle unless stalled; any result it yields is queued.
// The front classifies each byte against the frame state combinationally.
// A two-entry queue separates front and output; input stalls only while it is full.
// Reset sets max_payload_bytes to 1048576 and starts header gathering with no state held.
`include "length_prefix_deframer_unit_macros.svh"

module length_prefix_deframer_unit #(
  parameter int unsigned PREFIX_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        stream_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        byte_valid_o,
  output logic        last_byte_o,
  output logic [2:0]  status_o,
  output logic        status_valid_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);
  import lpd_pkg::*;

  logic        accept;
  logic        push;
  logic        full;
  lpd_result_t push_data;
  lpd_result_t head;

  assign accept     = in_valid_i && !full;
  assign in_stall_o = full;

  lpd_front #(
    .PREFIX_BYTES(PREFIX_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .stream_end_i(stream_end_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_o      (push),
    .result_o    (push_data)
  );

  lpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (!out_stall_i),
    .full_o     (full),
    .valid_o    (out_valid_o),
    .head_o     (head)
  );

  // Drive the result fields from the queue head
  assign payload_byte_o = head.payload_byte;
  assign byte_valid_o   = head.byte_valid;
  assign last_byte_o    = head.last_byte;
  assign status_o       = head.status;
  assign status_valid_o = head.status_valid;

  `LPD_ASSERT_SAME(a_last_carries_ok, out_valid_o && last_byte_o, byte_valid_o && status_valid_o && (status_o == ST_OK), "last byte without ok status")
  `LPD_ASSERT_SAME(a_status_only_on_last, out_valid_o && byte_valid_o && status_valid_o, last_byte_o, "status on a middle payload byte")
  `LPD_ASSERT_SAME(a_bare_status_not_ok, out_valid_o && status_valid_o && !byte_valid_o, status_o != ST_OK, "ok status without a payload byte")
  `LPD_ASSERT_SAME(a_stall_means_backlog, in_stall_o, out_valid_o, "input stalled with nothing to deliver")

endmodule

@@ sim/length_prefix_deframer_unit_tb.sv @@
`timescale 1ns / 100ps

module length_prefix_deframer_unit_tb;
  import lpd_pkg::*;

  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned PHASE_TXNS  = 170;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned NUM_PHASES  = 6;

  // One row of directed stimulus; typed rows carry their outcome written out
  typedef struct {
    logic [7:0]  b;
    logic        eos;
    bit          typed;
    bit          has_res;
    lpd_result_t res;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        stream_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  payload_byte_o;
  logic        byte_valid_o;
  logic        last_byte_o;
  logic [2:0]  status_o;
  logic        status_valid_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  // Deframer state as the predictor sees it
  logic [31:0] max_len;
  bit          in_frame;
  logic [2:0]  hdr_cnt;
  logic [31:0] len_acc;
  logic [31:0] remaining;

  lpd_result_t due_results[$];
  lpd_result_t want;
  stim_row_t   dir_rows[$];
  int unsigned stream_txns;
  int unsigned results_seen;
  int unsigned bytes_seen;
  int unsigned outcome_cnt[6];
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;
  bit          calm;
  int          hold_left;
  logic [31:0] phase_max[NUM_PHASES];

  length_prefix_deframer_unit #(
    .PREFIX_BYTES(HDR_BYTES)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .stream_end_i  (stream_end_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .payload_byte_o(payload_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_byte_o   (last_byte_o),
    .status_o      (status_o),
    .status_valid_o(status_valid_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drop any partial frame and go back to header gathering
  function automatic void restart_gather();
    in_frame  = 1'b0;
    hdr_cnt   = '0;
    len_acc   = '0;
    remaining = '0;
  endfunction

  // Advance the frame state by one transaction; return 1 when it yields a result
  function automatic bit deframe_step(input logic [7:0] b, input logic eos,
                                      output lpd_result_t res);
    logic [31:0] got_len;
    res = '0;
    if (eos) begin
      if (in_frame) begin
        res.status = ST_TRUNC_PAY;
      end else if (hdr_cnt == 3'd0) begin
        res.status = ST_EOS;
      end else begin
        res.status = ST_TRUNC_HDR;
      end
      res.status_valid = 1'b1;
      restart_gather();
      return 1'b1;
    end
    if (in_frame) begin
      if (remaining != 0) remaining = remaining - 1;
      res.payload_byte = b;
      res.byte_valid   = 1'b1;
      if (remaining == 0) begin
        restart_gather();
        res.last_byte    = 1'b1;
        res.status       = ST_OK;
        res.status_valid = 1'b1;
      end
      return 1'b1;
    end
    // Saturate a length that would not fit in 32 bits
    if (len_acc[31:24] != 8'd0) begin
      len_acc = '1;
    end else begin
      len_acc = {len_acc[23:0], b};
    end
    hdr_cnt = hdr_cnt + 3'd1;
    if (hdr_cnt == 3'(HDR_BYTES)) begin
      got_len = len_acc;
      hdr_cnt = '0;
      len_acc = '0;
      if (got_len == 0) begin
        res.status       = ST_EMPTY;
        res.status_valid = 1'b1;
        return 1'b1;
      end
      if (got_len > max_len) begin
        res.status       = ST_TOO_LARGE;
        res.status_valid = 1'b1;
        return 1'b1;
      end
      in_frame  = 1'b1;
      remaining = got_len;
    end
    return 1'b0;
  endfunction

  function automatic stim_row_t open_row(input logic [7:0] b, input logic eos);
    stim_row_t r;
    r.b = b;
    r.eos = eos;
    r.typed = 1'b0;
    r.has_res = 1'b0;
    r.res = '0;
    return r;
  endfunction

  // Header byte that must produce nothing
  function automatic stim_row_t quiet_row(input logic [7:0] b);
    stim_row_t r;
    r = open_row(b, 1'b0);
    r.typed = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t outcome_row(input logic [7:0] b, input logic eos,
                                            input lpd_status_e st);
    stim_row_t r;
    r = open_row(b, eos);
    r.typed = 1'b1;
    r.has_res = 1'b1;
    r.res.status = st;
    r.res.status_valid = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t pass_row(input logic [7:0] b, input logic lb);
    stim_row_t r;
    r = open_row(b, 1'b0);
    r.typed = 1'b1;
    r.has_res = 1'b1;
    r.res.payload_byte = b;
    r.res.byte_valid = 1'b1;
    r.res.last_byte = lb;
    r.res.status = ST_OK;
    r.res.status_valid = lb;
    return r;
  endfunction

  // Offer one transaction, hold it until taken, then log what it should produce
  task automatic send_item(input stim_row_t row);
    lpd_result_t res;
    bit          has;
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    data_byte_i  = row.b;
    stream_end_i = row.eos;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    has = deframe_step(row.b, row.eos, res);
    if (row.typed) begin
      has = row.has_res;
      res = row.res;
    end
    if (has) due_results.push_back(res);
    stream_txns++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_header(input logic [31:0] len, input int unsigned n);
    for (int i = HDR_BYTES - 1; i >= int'(HDR_BYTES - n); i--) begin
      send_item(open_row((i < 4) ? len[8*i +: 8] : 8'd0, 1'b0));
    end
  endtask

  task automatic send_end();
    send_item(open_row(8'($urandom_range(0, 255)), 1'b1));
  endtask

  // Send a full header, then up to take payload bytes of an accepted frame, plus an end if cut short
  task automatic send_frame(input logic [31:0] len, input int unsigned take);
    int unsigned n;
    send_header(len, HDR_BYTES);
    if (len != 0 && len <= max_len) begin
      n = (take < len) ? take : len;
      repeat (n) send_item(open_row(8'($urandom_range(0, 255)), 1'b0));
      if (n < len) send_end();
    end
  endtask

  task automatic random_frame();
    int unsigned kind;
    int unsigned cap;
    logic [31:0] len;
    kind = $urandom_range(0, 99);
    cap  = (max_len < 24) ? max_len : 24;
    if (kind < 60) begin
      len = (cap == 0) ? 32'd1 : 32'($urandom_range(1, cap));
      send_frame(len, len);
    end else if (kind < 68) begin
      send_frame(32'd0, 0);
    end else if (kind < 76) begin
      if (max_len == 32'hFFFF_FFFF) begin
        send_frame(32'hFFFF_FFFF, $urandom_range(0, 4));
      end else begin
        len = max_len + 32'($urandom_range(1, 4));
        if (len <= max_len) len = 32'hFFFF_FFFF;
        send_frame(len, 0);
      end
    end else if (kind < 84) begin
      len = (max_len == 0) ? 32'd1 :
            32'($urandom_range(1, (max_len < 65535) ? max_len : 65535));
      send_frame(len, $urandom_range(0, (len - 1 < 30) ? len - 1 : 30));
    end else if (kind < 88) begin
      send_frame($urandom, $urandom_range(0, 5));
    end else if (kind < 93) begin
      send_header($urandom, $urandom_range(1, HDR_BYTES - 1));
      send_end();
    end else if (kind < 96) begin
      send_end();
    end else begin
      repeat ($urandom_range(1, 6)) send_item(open_row(8'($urandom_range(0, 255)), 1'b0));
      send_end();
    end
  endtask

  // Hold the sender until every expected result is out, then let the pipe settle
  task automatic drain();
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_max(input logic [31:0] v);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    max_len  = v;
  endtask

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endfunction

  // Receiver: random stalls, calm stretches and long hold-offs on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = ($urandom_range(0, 99) < 29);
      end
    end
  end

  // Compare each result transaction with the oldest one due
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (due_results.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result with none due, expected nothing, actual byte %0h status %0d",
                 $time, payload_byte_o, status_o);
      end else begin
        want = due_results.pop_front();
        check_field("payload_byte", want.payload_byte, payload_byte_o);
        check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid_o));
        check_field("last_byte", 8'(want.last_byte), 8'(last_byte_o));
        check_field("status", 8'(want.status), 8'(status_o));
        check_field("status_valid", 8'(want.status_valid), 8'(status_valid_o));
        if (want.byte_valid) bytes_seen++;
        if (want.status_valid) outcome_cnt[want.status]++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_cnt,
               due_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = '0;
    stream_end_i = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    calm         = 1'b0;
    hold_left    = 0;
    max_len      = MAX_RESET;
    restart_gather();
    phase_max = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd17,
                  32'($urandom_range(2, 64)), MAX_RESET};

    // Directed rows: lone end, empty frame, two-byte frame, limits around the reset maximum, cut header
    dir_rows.push_back(outcome_row(8'h00, 1'b1, ST_EOS));
    repeat (3) dir_rows.push_back(quiet_row(8'h00));
    dir_rows.push_back(outcome_row(8'h00, 1'b0, ST_EMPTY));
    repeat (3) dir_rows.push_back(quiet_row(8'h00));
    dir_rows.push_back(quiet_row(8'h02));
    dir_rows.push_back(pass_row(8'hFF, 1'b0));
    dir_rows.push_back(pass_row(8'h00, 1'b1));
    dir_rows.push_back(quiet_row(8'h00));
    dir_rows.push_back(quiet_row(8'h10));
    dir_rows.push_back(quiet_row(8'h00));
    dir_rows.push_back(outcome_row(8'h01, 1'b0, ST_TOO_LARGE));
    dir_rows.push_back(quiet_row(8'h00));
    dir_rows.push_back(quiet_row(8'h10));
    dir_rows.push_back(quiet_row(8'h00));
    dir_rows.push_back(quiet_row(8'h00));
    dir_rows.push_back(open_row(8'h5A, 1'b0));
    dir_rows.push_back(outcome_row(8'hA5, 1'b1, ST_TRUNC_PAY));
    dir_rows.push_back(quiet_row(8'hFF));
    dir_rows.push_back(quiet_row(8'hFF));
    dir_rows.push_back(outcome_row(8'hFF, 1'b1, ST_TRUNC_HDR));

    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_item(dir_rows[i]);
    drain();

    // Random phases, each under its own maximum
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_max(phase_max[p]);
      calm = (p == 3);
      if (max_len == 32'hFFFF_FFFF) send_frame(32'hFFFF_FFFF, 3);
      if (p == NUM_PHASES - 1) begin
        // Hold the output off while a long frame keeps arriving
        hold_left = 60;
        send_frame(32'd40, 40);
      end
      for (int unsigned goal = stream_txns + PHASE_TXNS; stream_txns < goal; ) begin
        random_frame();
      end
      drain();
    end
    calm = 1'b0;

    repeat (8) @(posedge clk_i);
    $display("Covered %0d input transactions and %0d results, %0d of them payload bytes",
             stream_txns, results_seen, bytes_seen);
    $display("Outcomes: ok %0d, end %0d, cut header %0d, empty %0d, too large %0d, cut payload %0d",
             outcome_cnt[ST_OK], outcome_cnt[ST_EOS], outcome_cnt[ST_TRUNC_HDR],
             outcome_cnt[ST_EMPTY], outcome_cnt[ST_TOO_LARGE], outcome_cnt[ST_TRUNC_PAY]);
    if (mismatch_cnt == 0 && due_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lpd_pkg.sv
sv/lpd_front.sv
sv/lpd_queue.sv
sv/length_prefix_deframer_unit.sv
sim/length_prefix_deframer_unit_tb.sv
